>>> design/tpc_pkg.sv
package tpc_pkg;

    // coordinate format
    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int CLR_W  = 24;

    // widths that follow from the coordinate format
    localparam int PW     = 2 * CW + 1;   // normal times (v - p)
    localparam int DW     = 2 * CW + 3;   // sum of three products
    localparam int RW     = DW + 1;       // divider partial remainder
    localparam int MW     = CW + FB + 2;  // edge delta times t

    // config register file
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_PX = 3'd0;
    localparam logic [IDX_W-1:0] REG_PY = 3'd1;
    localparam logic [IDX_W-1:0] REG_PZ = 3'd2;
    localparam logic [IDX_W-1:0] REG_NX = 3'd3;
    localparam logic [IDX_W-1:0] REG_NY = 3'd4;
    localparam logic [IDX_W-1:0] REG_NZ = 3'd5;

    localparam logic [CW-1:0] PZ_RST = CW'(((1 << FB) + 5) / 10);
    localparam logic [CW-1:0] NZ_RST = CW'(1 << FB);

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [DW-1:0] dist_t;
    typedef logic signed [MW-1:0] mul_t;

    // one vertex, axis 0 is x, 1 is y, 2 is z
    typedef logic [2:0][CW-1:0] vtx_t;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_TWO  = 2'd2
    } kind_t;

    // classified triangle: edge A is ea->eb, edge B is fa->fb
    typedef struct packed {
        kind_t              kind;
        logic [CLR_W-1:0]   colour;
        vtx_t               ea;
        vtx_t               eb;
        vtx_t               fa;
        vtx_t               fb;
        dist_t              d_ea;
        dist_t              d_eb;
        dist_t              d_fa;
        dist_t              d_fb;
    } clip_item_t;

endpackage

>>> design/tpc_front.sv
module tpc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tpc_pkg::IDX_W-1:0]    cfg_idx,
    input  logic [tpc_pkg::CW-1:0]       cfg_data,
    input  logic                         push,
    output logic                         full,
    input  tpc_pkg::vtx_t                in_v0,
    input  tpc_pkg::vtx_t                in_v1,
    input  tpc_pkg::vtx_t                in_v2,
    input  logic [tpc_pkg::CLR_W-1:0]    in_colour,
    output logic                         q_push,
    output tpc_pkg::clip_item_t          q_item,
    input  logic                         q_full
);
    import tpc_pkg::*;

    vtx_t               pp_reg;
    vtx_t               pn_reg;

    logic               f1_valid_reg;
    logic               f2_valid_reg;
    logic               f3_valid_reg;
    vtx_t               f1_v_reg [3];
    vtx_t               f2_v_reg [3];
    vtx_t               f3_v_reg [3];
    logic [CLR_W-1:0]   f1_col_reg;
    logic [CLR_W-1:0]   f2_col_reg;
    logic [CLR_W-1:0]   f3_col_reg;
    logic [CW:0]        f1_diff_reg [3][3];
    prod_t              f2_prod_reg [3][3];
    dist_t              f3_dist_reg [3];

    vtx_t               in_v [3];
    logic               adv;
    logic               keep;
    logic [2:0]         ins;
    kind_t              kind;
    logic [1:0]         i_ea;
    logic [1:0]         i_eb;
    logic [1:0]         i_fa;
    logic [1:0]         i_fb;

    assign in_v[0] = in_v0;
    assign in_v[1] = in_v1;
    assign in_v[2] = in_v2;

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_reg <= {PZ_RST, CW'(0), CW'(0)};
            pn_reg <= {NZ_RST, CW'(0), CW'(0)};
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_PX: pp_reg[0] <= cfg_data;
                REG_PY: pp_reg[1] <= cfg_data;
                REG_PZ: pp_reg[2] <= cfg_data;
                REG_NX: pn_reg[0] <= cfg_data;
                REG_NY: pn_reg[1] <= cfg_data;
                REG_NZ: pn_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole front stalls only when the tail beat cannot enter the queue
    assign adv  = !(f3_valid_reg && keep && q_full);
    assign full = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= push;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    // distance pipeline: v - p, n * (v - p), sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    f1_diff_reg[i][k] <= $signed({in_v[i][k][CW-1], in_v[i][k]})
                                       - $signed({pp_reg[k][CW-1], pp_reg[k]});
                    f2_prod_reg[i][k] <= prod_t'($signed(pn_reg[k]))
                                       * prod_t'($signed(f1_diff_reg[i][k]));
                end
                f3_dist_reg[i] <= dist_t'(f2_prod_reg[i][0]) + dist_t'(f2_prod_reg[i][1])
                                + dist_t'(f2_prod_reg[i][2]);
                f1_v_reg[i] <= in_v[i];
                f2_v_reg[i] <= f1_v_reg[i];
                f3_v_reg[i] <= f2_v_reg[i];
            end
            f1_col_reg <= in_colour;
            f2_col_reg <= f1_col_reg;
            f3_col_reg <= f2_col_reg;
        end
    end

    // inside test and vertex roles
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            ins[i] = ~f3_dist_reg[i][DW-1];
        keep = 1'b1;
        kind = KIND_PASS;
        i_ea = 2'd0;
        i_eb = 2'd1;
        i_fa = 2'd0;
        i_fb = 2'd2;
        unique case (ins)
            3'b111: ;
            3'b001: begin kind = KIND_ONE; end
            3'b010:
            begin
                kind = KIND_ONE; i_ea = 2'd1; i_eb = 2'd0; i_fa = 2'd1; i_fb = 2'd2;
            end
            3'b100:
            begin
                kind = KIND_ONE; i_ea = 2'd2; i_eb = 2'd0; i_fa = 2'd2; i_fb = 2'd1;
            end
            3'b011:
            begin
                kind = KIND_TWO; i_ea = 2'd0; i_eb = 2'd2; i_fa = 2'd1; i_fb = 2'd2;
            end
            3'b101:
            begin
                kind = KIND_TWO; i_ea = 2'd0; i_eb = 2'd1; i_fa = 2'd2; i_fb = 2'd1;
            end
            3'b110:
            begin
                kind = KIND_TWO; i_ea = 2'd1; i_eb = 2'd0; i_fa = 2'd2; i_fb = 2'd0;
            end
            default: keep = 1'b0;
        endcase
    end

    assign q_push        = f3_valid_reg && keep && !q_full;
    assign q_item.kind   = kind;
    assign q_item.colour = f3_col_reg;
    assign q_item.ea     = f3_v_reg[i_ea];
    assign q_item.eb     = f3_v_reg[i_eb];
    assign q_item.fa     = f3_v_reg[i_fa];
    assign q_item.fb     = f3_v_reg[i_fb];
    assign q_item.d_ea   = f3_dist_reg[i_ea];
    assign q_item.d_eb   = f3_dist_reg[i_eb];
    assign q_item.d_fa   = f3_dist_reg[i_fa];
    assign q_item.d_fb   = f3_dist_reg[i_fb];

endmodule

>>> design/tpc_queue.sv
module tpc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  tpc_pkg::clip_item_t  din,
    output logic                 full,
    input  logic                 rd,
    output tpc_pkg::clip_item_t  dout,
    output logic                 empty
);
    import tpc_pkg::*;

    clip_item_t       mem [QDEPTH];
    logic [QAW-1:0]   wp_reg;
    logic [QAW-1:0]   rp_reg;
    logic [QAW:0]     cnt_reg;

    assign full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= din;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> design/tpc_back.sv
module tpc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  tpc_pkg::clip_item_t          q_item,
    output logic                         q_pop,
    output tpc_pkg::vtx_t                o_v0,
    output tpc_pkg::vtx_t                o_v1,
    output tpc_pkg::vtx_t                o_v2,
    output logic [tpc_pkg::CLR_W-1:0]    o_colour,
    output logic                         o_last,
    output logic                         empty,
    input  logic                         pop
);
    import tpc_pkg::*;

    // divider pipe: stage 0 loads, stages 1..FB each retire one quotient bit
    logic               dv_valid_reg [FB+1];
    clip_item_t         dv_item_reg  [FB+1];
    logic [RW-1:0]      ra_reg [FB+1];
    logic [RW-1:0]      rb_reg [FB+1];
    logic [DW-1:0]      na_reg [FB+1];
    logic [DW-1:0]      nb_reg [FB+1];
    logic [FB-1:0]      qa_reg [FB+1];
    logic [FB-1:0]      qb_reg [FB+1];

    logic [RW-1:0]      sha [FB];
    logic [RW-1:0]      shb [FB];
    logic               gea [FB];
    logic               geb [FB];
    logic [RW-1:0]      ra_nx [FB];
    logic [RW-1:0]      rb_nx [FB];
    logic [FB-1:0]      qa_nx [FB];
    logic [FB-1:0]      qb_nx [FB];

    // multiply and add stages
    logic               m_valid_reg;
    clip_item_t         m_item_reg;
    mul_t               ma_reg [3];
    mul_t               mb_reg [3];
    mul_t               ma_nx [3];
    mul_t               mb_nx [3];

    logic               l_valid_reg;
    clip_item_t         l_item_reg;
    vtx_t               l_pa_reg;
    vtx_t               l_pb_reg;
    logic               l_idx_reg;
    vtx_t               pa_nx;
    vtx_t               pb_nx;
    mul_t               sha_m [3];
    mul_t               shb_m [3];

    logic               adv;
    logic               last_now;

    // one result beat per cycle while pop is held; a two-triangle item holds the pipe one beat
    assign empty    = !l_valid_reg;
    assign last_now = (l_item_reg.kind != KIND_TWO) || l_idx_reg;
    assign adv      = !l_valid_reg || (pop && last_now);
    assign q_pop    = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= FB; s++)
                dv_valid_reg[s] <= 1'b0;
            m_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
            l_idx_reg   <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= q_pop;
            for (int s = 0; s < FB; s++)
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            m_valid_reg <= dv_valid_reg[FB];
            l_valid_reg <= m_valid_reg;
            l_idx_reg   <= 1'b0;
        end
        else if (pop && l_valid_reg)
        begin
            l_idx_reg <= 1'b1;
        end
    end

    // restoring divide step for both edges
    always_comb
    begin
        for (int k = 0; k < FB; k++)
        begin
            sha[k]   = {ra_reg[k][RW-2:0], 1'b0};
            shb[k]   = {rb_reg[k][RW-2:0], 1'b0};
            gea[k]   = (sha[k] >= RW'(na_reg[k]));
            geb[k]   = (shb[k] >= RW'(nb_reg[k]));
            ra_nx[k] = gea[k] ? (sha[k] - RW'(na_reg[k])) : sha[k];
            rb_nx[k] = geb[k] ? (shb[k] - RW'(nb_reg[k])) : shb[k];
            qa_nx[k] = {qa_reg[k][FB-2:0], gea[k]};
            qb_nx[k] = {qb_reg[k][FB-2:0], geb[k]};
        end
    end

    // (b - a) * t for each axis of both edges
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ma_nx[k] = mul_t'($signed({dv_item_reg[FB].eb[k][CW-1], dv_item_reg[FB].eb[k]})
                     - $signed({dv_item_reg[FB].ea[k][CW-1], dv_item_reg[FB].ea[k]}))
                     * mul_t'($signed({1'b0, qa_reg[FB]}));
            mb_nx[k] = mul_t'($signed({dv_item_reg[FB].fb[k][CW-1], dv_item_reg[FB].fb[k]})
                     - $signed({dv_item_reg[FB].fa[k][CW-1], dv_item_reg[FB].fa[k]}))
                     * mul_t'($signed({1'b0, qb_reg[FB]}));
        end
    end

    // a + floor(product / 2^FB), wrapped to coordinate width
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sha_m[k] = ma_reg[k] >>> FB;
            shb_m[k] = mb_reg[k] >>> FB;
            pa_nx[k] = m_item_reg.ea[k] + sha_m[k][CW-1:0];
            pb_nx[k] = m_item_reg.fa[k] + shb_m[k][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_item_reg[0] <= q_item;
            ra_reg[0]      <= RW'(q_item.d_ea);
            rb_reg[0]      <= RW'(q_item.d_fa);
            na_reg[0]      <= DW'(q_item.d_ea - q_item.d_eb);
            nb_reg[0]      <= DW'(q_item.d_fa - q_item.d_fb);
            qa_reg[0]      <= '0;
            qb_reg[0]      <= '0;
            for (int s = 0; s < FB; s++)
            begin
                dv_item_reg[s+1] <= dv_item_reg[s];
                ra_reg[s+1]      <= ra_nx[s];
                rb_reg[s+1]      <= rb_nx[s];
                na_reg[s+1]      <= na_reg[s];
                nb_reg[s+1]      <= nb_reg[s];
                qa_reg[s+1]      <= qa_nx[s];
                qb_reg[s+1]      <= qb_nx[s];
            end
            m_item_reg <= dv_item_reg[FB];
            for (int k = 0; k < 3; k++)
            begin
                ma_reg[k] <= ma_nx[k];
                mb_reg[k] <= mb_nx[k];
            end
            l_item_reg <= m_item_reg;
            l_pa_reg   <= pa_nx;
            l_pb_reg   <= pb_nx;
        end
    end

    // assemble the result beat
    assign o_colour = l_item_reg.colour;
    assign o_last   = last_now;

    always_comb
    begin
        unique case (l_item_reg.kind)
            KIND_ONE:
            begin
                o_v0 = l_item_reg.ea;
                o_v1 = l_pa_reg;
                o_v2 = l_pb_reg;
            end
            KIND_TWO:
            begin
                o_v0 = l_idx_reg ? l_item_reg.fa : l_item_reg.ea;
                o_v1 = l_idx_reg ? l_pa_reg      : l_item_reg.fa;
                o_v2 = l_idx_reg ? l_pb_reg      : l_pa_reg;
            end
            default:
            begin
                o_v0 = l_item_reg.ea;
                o_v1 = l_item_reg.eb;
                o_v2 = l_item_reg.fb;
            end
        endcase
    end

endmodule

>>> design/triangle_plane_clipper.sv
// channel   direction  handshake            payload
// config    in         cfg_we               cfg_idx, cfg_data
// triangle  in         push / full          v0_x .. v2_z, tri_colour
// result    out        pop / empty          out_v0_x .. out_v2_z, out_colour, last_of_run
//
// One triangle beat can be taken every cycle while full is low; a triangle that splits in
// two leaves as two result beats, which bounds throughput.
// A triangle passes the distance pipe, the queue, then the back end, where the restoring
// divider retires one quotient bit per stage.
// Reset is asynchronous; it empties all pipes and the queue and loads the default plane.
// A stalled result holds the back pipe; the queue lets the front keep taking beats until it fills.
module triangle_plane_clipper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpc_pkg::IDX_W-1:0]           cfg_idx,
    input  logic [tpc_pkg::CW-1:0]              cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [tpc_pkg::CW-1:0]       v0_x,
    input  logic signed [tpc_pkg::CW-1:0]       v0_y,
    input  logic signed [tpc_pkg::CW-1:0]       v0_z,
    input  logic signed [tpc_pkg::CW-1:0]       v1_x,
    input  logic signed [tpc_pkg::CW-1:0]       v1_y,
    input  logic signed [tpc_pkg::CW-1:0]       v1_z,
    input  logic signed [tpc_pkg::CW-1:0]       v2_x,
    input  logic signed [tpc_pkg::CW-1:0]       v2_y,
    input  logic signed [tpc_pkg::CW-1:0]       v2_z,
    input  logic [tpc_pkg::CLR_W-1:0]           tri_colour,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [tpc_pkg::CW-1:0]       out_v0_x,
    output logic signed [tpc_pkg::CW-1:0]       out_v0_y,
    output logic signed [tpc_pkg::CW-1:0]       out_v0_z,
    output logic signed [tpc_pkg::CW-1:0]       out_v1_x,
    output logic signed [tpc_pkg::CW-1:0]       out_v1_y,
    output logic signed [tpc_pkg::CW-1:0]       out_v1_z,
    output logic signed [tpc_pkg::CW-1:0]       out_v2_x,
    output logic signed [tpc_pkg::CW-1:0]       out_v2_y,
    output logic signed [tpc_pkg::CW-1:0]       out_v2_z,
    output logic [tpc_pkg::CLR_W-1:0]           out_colour,
    output logic                                last_of_run
);
    import tpc_pkg::*;

    vtx_t          in_v0;
    vtx_t          in_v1;
    vtx_t          in_v2;
    vtx_t          o_v0;
    vtx_t          o_v1;
    vtx_t          o_v2;
    clip_item_t    fq_item;
    clip_item_t    qb_item;
    logic          fq_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign in_v0 = {v0_z, v0_y, v0_x};
    assign in_v1 = {v1_z, v1_y, v1_x};
    assign in_v2 = {v2_z, v2_y, v2_x};

    tpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_v0     (in_v0),
        .in_v1     (in_v1),
        .in_v2     (in_v2),
        .in_colour (tri_colour),
        .q_push    (fq_push),
        .q_item    (fq_item),
        .q_full    (q_full)
    );

    tpc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fq_push),
        .din   (fq_item),
        .full  (q_full),
        .rd    (q_pop),
        .dout  (qb_item),
        .empty (q_empty)
    );

    tpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (qb_item),
        .q_pop    (q_pop),
        .o_v0     (o_v0),
        .o_v1     (o_v1),
        .o_v2     (o_v2),
        .o_colour (out_colour),
        .o_last   (last_of_run),
        .empty    (empty),
        .pop      (pop)
    );

    assign out_v0_x = o_v0[0];
    assign out_v0_y = o_v0[1];
    assign out_v0_z = o_v0[2];
    assign out_v1_x = o_v1[0];
    assign out_v1_y = o_v1[1];
    assign out_v1_z = o_v1[2];
    assign out_v2_x = o_v2[0];
    assign out_v2_y = o_v2[1];
    assign out_v2_z = o_v2[2];

endmodule
